[rtl/bxds_pkg.sv]
// Shared widths, codes and types of the box average image downscaler.
package bxds_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 9;
    localparam int DIM_W     = 13;
    localparam int CNT_W     = 18;
    localparam int SUM_W     = 26;
    localparam int Q_W       = 9;
    localparam int DSH_W     = CNT_W + Q_W - 1;
    localparam int PIX_W     = 24;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [2:0] DSEL_X0 = 3'd0;
    localparam logic [2:0] DSEL_X1 = 3'd1;
    localparam logic [2:0] DSEL_Y0 = 3'd2;
    localparam logic [2:0] DSEL_Y1 = 3'd3;
    localparam logic [2:0] DSEL_AR = 3'd4;
    localparam logic [2:0] DSEL_AG = 3'd5;
    localparam logic [2:0] DSEL_AB = 3'd6;

    typedef struct packed {
        logic [7:0] out_y;
        logic [7:0] out_x;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] pix_y;
        logic [7:0] pix_x;
    } t_in_item;

    typedef struct packed {
        logic       load_pix;
        logic       latch_query;
        logic       div_start;
        logic [2:0] div_sel;
        logic       walk_init;
        logic       walk_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic box_empty;
        logic walk_last;
    } t_status;

endpackage

[rtl/bxds_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module bxds_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bxds_pkg::SUM_W-1:0] i_dividend,
    input  logic [bxds_pkg::CNT_W-1:0] i_divisor,
    output logic [bxds_pkg::Q_W-1:0]   o_quot,
    output logic                      o_done
);
    import bxds_pkg::*;

    localparam int STEP_W = $clog2(Q_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [Q_W-1:0]    r_q;
    logic              w_ge;

    assign w_ge = (SUM_W'(r_dsh) <= r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= {i_divisor, {(Q_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - SUM_W'(r_dsh);
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

[rtl/bxds_dp.sv]
// Datapath: registers, pixel store, box walk, accumulators and output register.
module bxds_dp #(
    parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bxds_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [bxds_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  bxds_pkg::t_in_item            i_item,
    input  bxds_pkg::t_cmd                i_cmd,
    output bxds_pkg::t_status             o_status,
    output logic [bxds_pkg::OUT_W-1:0]     o_data,
    output logic                          o_bad
);
    import bxds_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] MW = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MH = DIM_W'(MAX_HEIGHT);

    function automatic logic [COORD_W-1:0] f_end(
        input logic [COORD_W-1:0] q,
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] src
    );
        logic [COORD_W:0] lo1;
        logic [COORD_W:0] b;
        lo1 = {1'b0, lo} + 1'b1;
        b   = (q <= lo) ? lo1 : {1'b0, q};
        return (b > {1'b0, src}) ? src : b[COORD_W-1:0];
    endfunction

    logic [CFG_W-1:0]   r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [7:0]         r_ox, r_oy;
    logic [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1, r_x, r_y;
    logic [SUM_W-1:0]   r_sum_r, r_sum_g, r_sum_b;
    logic [CNT_W-1:0]   r_cnt;
    logic [7:0]         r_avg_r, r_avg_g, r_avg_b;
    logic               r_rd_valid;
    logic [PIX_W-1:0]   r_rd_data;
    logic [PIX_W-1:0]   r_mem [DEPTH];
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_bad;

    logic [COORD_W-1:0] w_sw, w_sh;
    logic               w_bad;
    logic [COORD_W-1:0] w_mul_a, w_mul_b;
    logic [CNT_W-1:0]   w_prod;
    logic [SUM_W-1:0]   w_dividend;
    logic [CNT_W-1:0]   w_divisor;
    logic [Q_W-1:0]     w_quot;
    logic               w_div_done;
    logic [COORD_W:0]   w_x_next, w_y_next;
    logic               w_x_end, w_y_end;
    logic               w_we;
    logic [AW-1:0]      w_wr_addr, w_rd_addr;

    assign w_sw  = (DIM_W'(r_src_w) < MW) ? r_src_w : MW[COORD_W-1:0];
    assign w_sh  = (DIM_W'(r_src_h) < MH) ? r_src_h : MH[COORD_W-1:0];
    assign w_bad = ({1'b0, r_ox} >= r_dst_w) || ({1'b0, r_oy} >= r_dst_h);

    always_comb begin
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_dividend = '0;
        w_divisor  = CNT_W'(r_dst_w);
        unique case (i_cmd.div_sel)
            DSEL_X0: begin
                w_mul_a = {1'b0, r_ox};
                w_mul_b = w_sw;
            end
            DSEL_X1: begin
                w_mul_a = {1'b0, r_ox} + 1'b1;
                w_mul_b = w_sw;
            end
            DSEL_Y0: begin
                w_mul_a   = {1'b0, r_oy};
                w_mul_b   = w_sh;
                w_divisor = CNT_W'(r_dst_h);
            end
            DSEL_Y1: begin
                w_mul_a   = {1'b0, r_oy} + 1'b1;
                w_mul_b   = w_sh;
                w_divisor = CNT_W'(r_dst_h);
            end
            DSEL_AR: begin
                w_dividend = r_sum_r;
                w_divisor  = r_cnt;
            end
            DSEL_AG: begin
                w_dividend = r_sum_g;
                w_divisor  = r_cnt;
            end
            DSEL_AB: begin
                w_dividend = r_sum_b;
                w_divisor  = r_cnt;
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
        if (i_cmd.div_sel <= DSEL_Y1) begin
            w_dividend = SUM_W'(w_prod);
        end
    end

    bxds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    assign w_x_next = {1'b0, r_x} + 1'b1;
    assign w_y_next = {1'b0, r_y} + 1'b1;
    assign w_x_end  = (w_x_next == {1'b0, r_x1});
    assign w_y_end  = (w_y_next == {1'b0, r_y1});

    assign o_status.bad       = w_bad;
    assign o_status.div_done  = w_div_done;
    assign o_status.box_empty = (r_x1 <= r_x0) || (r_y1 <= r_y0);
    assign o_status.walk_last = w_x_end && w_y_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= CFG_W'(256);
            r_src_h    <= CFG_W'(256);
            r_dst_w    <= CFG_W'(64);
            r_dst_h    <= CFG_W'(64);
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.walk_step;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SRC_WIDTH:  r_src_w <= i_cfg_wdata;
                    CFG_SRC_HEIGHT: r_src_h <= i_cfg_wdata;
                    CFG_DST_WIDTH:  r_dst_w <= i_cfg_wdata;
                    CFG_DST_HEIGHT: r_dst_h <= i_cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_query) begin
            r_ox    <= i_item.out_x;
            r_oy    <= i_item.out_y;
            r_avg_r <= '0;
            r_avg_g <= '0;
            r_avg_b <= '0;
        end
        if (w_div_done) begin
            unique case (i_cmd.div_sel)
                DSEL_X0: r_x0    <= w_quot;
                DSEL_X1: r_x1    <= f_end(w_quot, r_x0, w_sw);
                DSEL_Y0: r_y0    <= w_quot;
                DSEL_Y1: r_y1    <= f_end(w_quot, r_y0, w_sh);
                DSEL_AR: r_avg_r <= w_quot[7:0];
                DSEL_AG: r_avg_g <= w_quot[7:0];
                DSEL_AB: r_avg_b <= w_quot[7:0];
                default: r_avg_r <= r_avg_r;
            endcase
        end
        if (i_cmd.walk_init) begin
            r_x     <= r_x0;
            r_y     <= r_y0;
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.walk_step) begin
                if (w_x_end) begin
                    r_x <= r_x0;
                    r_y <= w_y_next[COORD_W-1:0];
                end else begin
                    r_x <= w_x_next[COORD_W-1:0];
                end
            end
            if (r_rd_valid) begin
                r_sum_r <= r_sum_r + SUM_W'(r_rd_data[23:16]);
                r_sum_g <= r_sum_g + SUM_W'(r_rd_data[15:8]);
                r_sum_b <= r_sum_b + SUM_W'(r_rd_data[7:0]);
                r_cnt   <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_avg_b, r_avg_g, r_avg_r};
            r_out_bad  <= w_bad;
        end
    end

    assign w_we = i_cmd.load_pix && (DIM_W'(i_item.pix_x) < MW) && (DIM_W'(i_item.pix_y) < MH);
    assign w_wr_addr = AW'(32'(i_item.pix_y) * 32'(MAX_WIDTH) + 32'(i_item.pix_x));
    assign w_rd_addr = AW'(32'(r_y) * 32'(MAX_WIDTH) + 32'(r_x));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= {i_item.red, i_item.green, i_item.blue};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_data = r_out_data;
    assign o_bad  = r_out_bad;

endmodule

[rtl/bxds_ctrl.sv]
// Controller state machine that sequences loads, divisions, the box walk and delivery.
module bxds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  bxds_pkg::t_status  i_status,
    output bxds_pkg::t_cmd     o_cmd
);
    import bxds_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_DIV_GO    = 3'd2;
    localparam logic [2:0] S_DIV_WAIT  = 3'd3;
    localparam logic [2:0] S_WALK_INIT = 3'd4;
    localparam logic [2:0] S_WALK      = 3'd5;
    localparam logic [2:0] S_DRAIN     = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.div_sel = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_QUERY) begin
                        o_cmd.latch_query = 1'b1;
                        n_state           = S_CHECK;
                    end else begin
                        o_cmd.load_pix = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.bad) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = DSEL_X0;
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (r_idx == DSEL_Y1) begin
                        n_state = S_WALK_INIT;
                    end else if (r_idx == DSEL_AB) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = i_status.box_empty ? S_DONE : S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_idx   = DSEL_AR;
                n_state = S_DIV_GO;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= DSEL_X0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/box_average_image_downscaler_core.sv]
// Top level of the box average image downscaler: controller, datapath and checks.
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  load or query item
//  m_axis    out        m_axis_tvalid/m_axis_tready  box average result item
//  i_cfg     in         i_cfg_we                     size register write
//
// A load item writes the pixel store through its write port in the cycle it is accepted.
// A query walks its box through the pixel store read port, and the shared
// one-bit-per-cycle divider runs seven times for a nonempty box (four box edges, three
// channel averages). A query with an empty box skips the walk and the channel averages.
// An out-of-range query goes straight to delivery. The output register lets the next item
// in while a result waits; a query that finishes meanwhile holds until it drains.
// Reset restores the size registers; the pixel store is not cleared.
module box_average_image_downscaler_core #(
    parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bxds_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [bxds_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pix_x, pix_y, red, green, blue, out_x, out_y
    input  logic [bxds_pkg::IN_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // avg_red, avg_green, avg_blue
    output logic [bxds_pkg::OUT_W-1:0]     m_axis_tdata,
    // bad_coord
    output logic [0:0]                    m_axis_tuser
);
    import bxds_pkg::*;

    t_cmd     w_cmd;
    t_status  w_status;
    t_in_item w_item;

    assign w_item = t_in_item'(s_axis_tdata);

    bxds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bxds_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_data      (m_axis_tdata),
        .o_bad       (m_axis_tuser[0])
    );

    a_bad_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("out-of-range query delivered a nonzero color");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_QUERY))
        |=> !s_axis_tready)
        else $error("input still ready right after a query item");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result item appeared right after an accepted input item");

    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.walk_step |-> !w_status.box_empty)
        else $error("box walk started on an empty box");

endmodule
